// File: sv/srdn_pkg.sv
// Shared widths, types and constants for the stick radial dead-zone normalizer.
package srdn_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int SQ_W         = 2 * SAMPLE_BITS;
  localparam int RADIUS_BITS  = 15;
  localparam int RSQ_W        = 2 * RADIUS_BITS;
  localparam int CMP_W        = (SQ_W > RSQ_W) ? SQ_W : RSQ_W;
  localparam int RADIUS_RESET = 7849;
  localparam logic [RSQ_W-1:0] RSQ_RESET = RSQ_W'(RADIUS_RESET * RADIUS_RESET);

  localparam int Q15_FRAC     = 15;
  localparam int DIR_W        = 16;
  localparam int QUO_BITS     = DIR_W;
  localparam int DIV_W        = SAMPLE_BITS + Q15_FRAC;
  localparam int REM_W        = SAMPLE_BITS + 1;
  localparam int ROOT_STAGES  = SAMPLE_BITS;
  localparam int LATENCY      = 2 + ROOT_STAGES + QUO_BITS;

  localparam int IN_TDATA_W   = ((2 * SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = ((2 * DIR_W + 7) / 8) * 8;

  localparam logic [DIR_W-1:0] DIR_MAX = {1'b0, {(DIR_W-1){1'b1}}};

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic        [SAMPLE_BITS-1:0] mag_t;
  typedef logic        [SQ_W-1:0]        sq_t;
  typedef logic        [RSQ_W-1:0]       rsq_t;
  typedef logic signed [DIR_W-1:0]       dir_t;

  typedef struct packed {
    mag_t mag_x;
    mag_t mag_y;
    logic neg_x;
    logic neg_y;
    logic outside;
  } side_t;

endpackage

// File: sv/srdn_lane_front.sv
// Per-axis front lane: sign, magnitude and square of one stick component.
module srdn_lane_front import srdn_pkg::*; (
  input  logic    clk,
  input  logic    en,
  input  sample_t sample,
  output mag_t    mag,
  output logic    neg,
  output sq_t     sq
);

  mag_t raw;
  mag_t mag_nxt;
  sq_t  op;
  sq_t  sq_nxt;
  mag_t mag_r;
  logic neg_r;
  sq_t  sq_r;

  always_comb begin
    raw     = mag_t'(sample);
    mag_nxt = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
    op      = SQ_W'(mag_nxt);
    sq_nxt  = op * op;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r <= mag_nxt;
      neg_r <= raw[SAMPLE_BITS-1];
      sq_r  <= sq_nxt;
    end
  end

  assign mag = mag_r;
  assign neg = neg_r;
  assign sq  = sq_r;

endmodule

// File: sv/srdn_root.sv
// Merge of the lane squares, dead-zone compare and pipelined integer square root.
module srdn_root import srdn_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  sq_t   sq_x,
  input  sq_t   sq_y,
  input  rsq_t  rsq,
  input  side_t side_i,
  output mag_t  len,
  output side_t side_o
);

  sq_t   sum_nxt;
  logic  outside_nxt;
  side_t side_nxt;
  sq_t   sum_r;
  side_t side0_r;

  sq_t              rad_r  [ROOT_STAGES];
  logic [REM_W-1:0] rem_r  [ROOT_STAGES];
  mag_t             root_r [ROOT_STAGES];
  side_t            side_r [ROOT_STAGES];

  // Merge: sum the lane squares and compare exactly against radius squared.
  always_comb begin
    sum_nxt          = sq_x + sq_y;
    outside_nxt      = CMP_W'(sum_nxt) > CMP_W'(rsq);
    side_nxt         = side_i;
    side_nxt.outside = outside_nxt;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r   <= sum_nxt;
      side0_r <= side_nxt;
    end
  end

  // One result bit per stage, two operand bits consumed per stage.
  for (genvar i = 0; i < ROOT_STAGES; i++) begin : g_stage
    sq_t              rad_in;
    logic [REM_W-1:0] rem_in;
    mag_t             root_in;
    side_t            side_in;
    logic [REM_W+1:0] cur;
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] diff;
    logic             ge;

    if (i == 0) begin : g_first
      assign rad_in  = sum_r;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side0_r;
    end else begin : g_next
      assign rad_in  = rad_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign side_in = side_r[i-1];
    end

    assign cur   = {rem_in, rad_in[SQ_W-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign diff  = cur - trial;
    assign ge    = cur >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[i]  <= rad_in << 2;
        rem_r[i]  <= ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
        root_r[i] <= {root_in[SAMPLE_BITS-2:0], ge};
        side_r[i] <= side_in;
      end
    end
  end

  assign len    = root_r[ROOT_STAGES-1];
  assign side_o = side_r[ROOT_STAGES-1];

endmodule

// File: sv/srdn_lane_div.sv
// Per-axis divider lane: (mag << 15) / len, one quotient bit per stage, signed and saturated.
module srdn_lane_div import srdn_pkg::*; (
  input  logic clk,
  input  logic en,
  input  mag_t mag,
  input  logic neg,
  input  mag_t len,
  output dir_t dir
);

  logic [DIV_W-1:0]    rem_r [QUO_BITS-1];
  mag_t                len_r [QUO_BITS-1];
  logic [QUO_BITS-1:0] quo_r [QUO_BITS];
  logic                neg_r [QUO_BITS];

  for (genvar j = 0; j < QUO_BITS; j++) begin : g_stage
    localparam int SH = QUO_BITS - 1 - j;
    logic [DIV_W-1:0]    rem_in;
    mag_t                len_in;
    logic [QUO_BITS-1:0] quo_in;
    logic                neg_in;
    logic [DIV_W-1:0]    dv;
    logic                ge;

    if (j == 0) begin : g_first
      assign rem_in = {mag, {Q15_FRAC{1'b0}}};
      assign len_in = len;
      assign quo_in = '0;
      assign neg_in = neg;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign len_in = len_r[j-1];
      assign quo_in = quo_r[j-1];
      assign neg_in = neg_r[j-1];
    end

    assign dv = DIV_W'(len_in) << SH;
    assign ge = rem_in >= dv;

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[j] <= {quo_in[QUO_BITS-2:0], ge};
        neg_r[j] <= neg_in;
      end
    end

    // Hold remainder and divisor only where a later stage reads them.
    if (j < QUO_BITS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j] <= ge ? (rem_in - dv) : rem_in;
          len_r[j] <= len_in;
        end
      end
    end
  end

  logic [QUO_BITS-1:0] q;
  logic [DIR_W-1:0]    res;

  // Quotient never exceeds one in Q1.15; clamp the positive full-scale case.
  always_comb begin
    q = quo_r[QUO_BITS-1];
    if (neg_r[QUO_BITS-1]) begin
      res = ~q + 1'b1;
    end else if (q[QUO_BITS-1]) begin
      res = DIR_MAX;
    end else begin
      res = q;
    end
  end

  assign dir = $signed(res);

endmodule

// File: sv/stick_radial_deadzone_normalizer.sv
// Top level of the stick radial dead-zone normalizer.
//
// Input stream: one word per stick sample, in_tdata = {stick_y, stick_x}.
// Output stream: one word per sample, out_tdata = {dir_y, dir_x} in Q1.15,
// out_tuser = outside_zone. Samples at or inside the dead-zone circle give
// zero direction and outside_zone low; samples outside give the unit
// direction, each component truncated toward zero and clamped to Q1.15.
// Configuration: cfg_we/cfg_wdata write the dead-zone radius; its square is
// formed at the write and held. Write only while the stream is drained.
// Throughput: one word per cycle when not stalled. The path from acceptance
// to out_tvalid runs through the square and merge registers, the 16-stage
// square-root pipeline, the 16-stage divider lanes and the output register.
// Stall: the whole pipeline freezes while a result sits in the output
// register and out_tready is low; in_tready drops for that time, so no word
// is lost or repeated.
// Reset: rst_n (synchronous, active low) flushes all valid flags, empties the
// output register and restores the radius to 7849.
module stick_radial_deadzone_normalizer import srdn_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tdata: [15:0] stick_x, [31:16] stick_y
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // out_tdata: [15:0] dir_x, [31:16] dir_y
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // out_tuser: [0] outside_zone
  output logic                   out_tuser,
  input  logic                   cfg_we,
  input  logic [RADIUS_BITS-1:0] cfg_wdata
);

  logic adv;
  logic accept;
  logic out_tvalid_r;

  // Advance the pipeline unless a finished word is held back by the receiver.
  assign adv       = !out_tvalid_r || out_tready;
  assign in_tready = adv;
  assign accept    = in_tvalid && adv;

  // Radius register stores the square so the compare needs no multiplier.
  rsq_t rsq_r;
  rsq_t rsq_nxt;

  assign rsq_nxt = RSQ_W'(cfg_wdata) * RSQ_W'(cfg_wdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsq_r <= RSQ_RESET;
    end else if (cfg_we) begin
      rsq_r <= rsq_nxt;
    end
  end

  // Front lanes: one per axis.
  sample_t stick_x;
  sample_t stick_y;
  mag_t    mag_x;
  mag_t    mag_y;
  logic    neg_x;
  logic    neg_y;
  sq_t     sq_x;
  sq_t     sq_y;

  assign stick_x = $signed(in_tdata[SAMPLE_BITS-1:0]);
  assign stick_y = $signed(in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);

  srdn_lane_front u_front_x (
    .clk    (clk),
    .en     (adv),
    .sample (stick_x),
    .mag    (mag_x),
    .neg    (neg_x),
    .sq     (sq_x)
  );

  srdn_lane_front u_front_y (
    .clk    (clk),
    .en     (adv),
    .sample (stick_y),
    .mag    (mag_y),
    .neg    (neg_y),
    .sq     (sq_y)
  );

  // Merge the lanes, compare with the radius, take the floored length.
  side_t side_in;
  side_t side_out;
  mag_t  len;

  always_comb begin
    side_in         = '0;
    side_in.mag_x   = mag_x;
    side_in.mag_y   = mag_y;
    side_in.neg_x   = neg_x;
    side_in.neg_y   = neg_y;
  end

  srdn_root u_root (
    .clk    (clk),
    .en     (adv),
    .sq_x   (sq_x),
    .sq_y   (sq_y),
    .rsq    (rsq_r),
    .side_i (side_in),
    .len    (len),
    .side_o (side_out)
  );

  // Divider lanes: one per axis, sharing the length.
  dir_t dir_x;
  dir_t dir_y;

  srdn_lane_div u_div_x (
    .clk (clk),
    .en  (adv),
    .mag (side_out.mag_x),
    .neg (side_out.neg_x),
    .len (len),
    .dir (dir_x)
  );

  srdn_lane_div u_div_y (
    .clk (clk),
    .en  (adv),
    .mag (side_out.mag_y),
    .neg (side_out.neg_y),
    .len (len),
    .dir (dir_y)
  );

  // Track word validity across the whole pipeline, and the zone flag
  // across the divider stages.
  logic [LATENCY-1:0]  vld_r;
  logic [QUO_BITS-1:0] zone_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LATENCY-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zone_r <= {zone_r[QUO_BITS-2:0], side_out.outside};
    end
  end

  // Output register: hold while stalled, load the finished word otherwise.
  dir_t             dir_x_r;
  dir_t             dir_y_r;
  logic             zone_out_r;
  logic             zone_fin;

  assign zone_fin = zone_r[QUO_BITS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      out_tvalid_r <= vld_r[LATENCY-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dir_x_r    <= zone_fin ? dir_x : '0;
      dir_y_r    <= zone_fin ? dir_y : '0;
      zone_out_r <= zone_fin;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_TDATA_W'({dir_y_r, dir_x_r});
  assign out_tuser  = zone_out_r;

endmodule

// File: sv/srdn_checker.sv
// Port-level checks for the stick radial dead-zone normalizer, bound to the top level.
module srdn_checker import srdn_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser
);

  // A held output word keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output word changed while stalled");

  // Inside the dead zone both direction components are zero.
  a_inside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("nonzero direction inside dead zone");

  // Outside the dead zone the direction is never the zero vector.
  a_outside_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata != '0)
    else $error("zero direction outside dead zone");

  // A stalled output blocks the input side.
  a_stall_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input accepted while output stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind stick_radial_deadzone_normalizer srdn_checker u_srdn_checker (.*);

// File: bench/tb.sv
// Self-checking bench for the stick radial dead-zone normalizer.
module tb;
  import srdn_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int MISMATCH_SHOW = 10;

  // One result word as the block should return it.
  typedef struct packed {
    dir_t dir_x;
    dir_t dir_y;
    logic outside;
  } heading_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   cfg_we;
  logic [RADIUS_BITS-1:0] cfg_wdata;

  // Bench copy of the radius register, updated together with each write.
  logic [RADIUS_BITS-1:0] zone_radius;
  heading_t               expected_headings[$];

  // Random stalls on both sides are enabled only while this is set.
  bit idle_enable;
  int stall_left;
  int cycle_count;
  int mismatch_count;
  int words_checked;
  int outside_seen;
  int radius_settings;

  stick_radial_deadzone_normalizer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [15:0] stick_x, [31:16] stick_y
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [15:0] dir_x, [31:16] dir_y
    .out_tuser  (out_tuser),  // [0] outside_zone
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // floor(sqrt(n)) by trying each root bit from the top; roots here fit in 17 bits.
  function automatic longint floor_root(input longint n);
    longint root;
    longint trial;
    root = 0;
    for (int b = 16; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  // Scale one component to Q1.15 of the unit vector, truncate, clamp to the dir range.
  function automatic dir_t unit_component(input longint comp, input longint len);
    longint quo;
    quo = (comp * 32768) / len;
    if (quo > 32767) quo = 32767;
    if (quo < -32768) quo = -32768;
    return dir_t'(quo);
  endfunction

  function automatic heading_t predict_heading(input logic [RADIUS_BITS-1:0] radius,
                                               input sample_t x, input sample_t y);
    heading_t h;
    longint sx, sy, len_sq, rad_sq, len;
    sx = x;
    sy = y;
    len_sq = sx * sx + sy * sy;
    rad_sq = longint'(radius) * longint'(radius);
    h = '0;
    // On or inside the circle stays all zero; outside gives the unit direction.
    if (len_sq > rad_sq) begin
      len = floor_root(len_sq);
      h.dir_x = unit_component(sx, len);
      h.dir_y = unit_component(sy, len);
      h.outside = 1'b1;
    end
    return h;
  endfunction

  // Drive one sample at the falling edge, hold it until the block takes it,
  // then log what it must produce. Returns at the falling edge after acceptance
  // with in_tvalid still high; valid drops between words only for a random idle gap.
  task automatic send_sample(input sample_t x, input sample_t y);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_headings.push_back(predict_heading(zone_radius, x, y));
    @(negedge clk);
  endtask

  // Drop valid and hold until every expected word is back.
  task automatic drain_stream();
    in_tvalid <= 1'b0;
    while (expected_headings.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write the radius with the stream drained; the bench copy follows at once.
  task automatic set_radius(input logic [RADIUS_BITS-1:0] radius);
    drain_stream();
    cfg_we    <= 1'b1;
    cfg_wdata <= radius;
    @(negedge clk);
    cfg_we    <= 1'b0;
    zone_radius = radius;
    radius_settings++;
  endtask

  // Pick a sample aimed at the behavior that matters for the current radius.
  task automatic pick_sample(output sample_t x, output sample_t y);
    int     r, ax, ay, tmp, kind;
    int     corners[6];
    longint rest;
    corners = '{-32768, -32767, -1, 0, 1, 32767};
    r = zone_radius;
    kind = $urandom_range(0, 9);
    if (kind <= 4) begin
      // Hug the circle: one magnitude at random, the other within one unit of the edge.
      ax = (r == 0) ? $urandom_range(0, 2) : $urandom_range(0, r);
      rest = longint'(r) * r - longint'(ax) * ax;
      if (rest < 0) rest = 0;
      ay = int'(floor_root(rest)) + $urandom_range(0, 2) - 1;
      if (ay < 0) ay = 0;
      if (ay > 32767) ay = 32767;
      if ($urandom_range(0, 1)) begin
        tmp = ax;
        ax  = ay;
        ay  = tmp;
      end
      x = sample_t'($urandom_range(0, 1) ? -ax : ax);
      y = sample_t'($urandom_range(0, 1) ? -ay : ay);
    end else if (kind <= 6) begin
      x = sample_t'($urandom);
      y = sample_t'($urandom);
    end else if (kind == 7) begin
      // Well inside the zone.
      ax = $urandom_range(0, r / 2);
      ay = $urandom_range(0, r / 2);
      x = sample_t'($urandom_range(0, 1) ? -ax : ax);
      y = sample_t'($urandom_range(0, 1) ? -ay : ay);
    end else if (kind == 8) begin
      // Pure axis deflection.
      x = sample_t'($urandom);
      y = '0;
      if ($urandom_range(0, 1)) begin
        y = x;
        x = '0;
      end
    end else begin
      x = sample_t'(corners[$urandom_range(0, 5)]);
      y = sample_t'(corners[$urandom_range(0, 5)]);
    end
  endtask

  task automatic send_random(input int count);
    sample_t x, y;
    repeat (count) begin
      pick_sample(x, y);
      send_sample(x, y);
    end
  endtask

  // Directed corners at the reset radius, no write first.
  task automatic test_reset_radius();
    send_sample(16'sd0, 16'sd0);
    send_sample(16'sd7849, 16'sd0);       // exactly on the circle: inside
    send_sample(16'sd7850, 16'sd0);       // just past it: quotient 32768 clamps
    send_sample(16'sd0, -16'sd7850);      // negative axis keeps -32768
    send_sample(-16'sd32768, 16'sd0);
    send_sample(16'sd0, -16'sd32768);
    send_sample(16'sd32767, 16'sd32767);
    send_sample(-16'sd32768, -16'sd32768);
    send_sample(16'sd32767, -16'sd32768);
    send_sample(16'sd5550, 16'sd5550);    // diagonal just inside
    send_sample(16'sd5549, -16'sd5550);   // diagonal just inside
    send_sample(-16'sd1, 16'sd1);
  endtask

  // Zero radius: only the origin is inside, and a length of one is the smallest divisor.
  task automatic test_zero_radius();
    set_radius('0);
    send_sample(16'sd0, 16'sd0);
    send_sample(16'sd1, 16'sd0);
    send_sample(16'sd0, -16'sd1);
    send_sample(16'sd1, 16'sd1);
    send_sample(-16'sd1, -16'sd1);
    send_sample(16'sd3, 16'sd4);
  endtask

  // Largest radius: an axis point on the circle stays inside; points just past it and the corners get out.
  task automatic test_full_radius();
    set_radius(RADIUS_BITS'(32767));
    send_sample(16'sd32767, 16'sd0);      // on the circle
    send_sample(-16'sd32768, 16'sd0);
    send_sample(16'sd32767, 16'sd1);
    send_sample(16'sd23170, 16'sd23170);
    send_sample(-16'sd23170, 16'sd23171);
    send_sample(-16'sd32768, -16'sd32768);
  endtask

  // Several radius settings, each with a random batch under random stalls.
  task automatic test_random_radii();
    set_radius(RADIUS_BITS'(RADIUS_RESET));
    send_random(200);
    set_radius(RADIUS_BITS'($urandom));
    send_random(200);
    set_radius('0);
    send_random(200);
    set_radius(RADIUS_BITS'(32767));
    send_random(200);
    set_radius(RADIUS_BITS'($urandom_range(1, 200)));
    send_random(200);
    set_radius(RADIUS_BITS'($urandom));
    send_random(200);
  endtask

  // Full-rate traffic with no stalls on either side.
  task automatic test_back_to_back();
    set_radius(RADIUS_BITS'($urandom_range(1000, 20000)));
    idle_enable = 1'b0;
    send_random(300);
  endtask

  // Receiver side: hold ready low for random bursts while stalls are enabled.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else if (idle_enable && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      stall_left = $urandom_range(1, 14) - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare each word taken from the block with the oldest prediction.
  always @(posedge clk) begin
    heading_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got.dir_x   = dir_t'(out_tdata[15:0]);
      got.dir_y   = dir_t'(out_tdata[31:16]);
      got.outside = out_tuser;
      if (expected_headings.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MISMATCH_SHOW)
          $display("unexpected word: dir_x=%0d dir_y=%0d outside=%0b",
                   got.dir_x, got.dir_y, got.outside);
      end else begin
        want = expected_headings.pop_front();
        if (got.dir_x !== want.dir_x || got.dir_y !== want.dir_y ||
            got.outside !== want.outside) begin
          mismatch_count++;
          if (mismatch_count <= MISMATCH_SHOW)
            $display("word %0d: expected dir_x=%0d dir_y=%0d outside=%0b, got %0d %0d %0b",
                     words_checked, want.dir_x, want.dir_y, want.outside,
                     got.dir_x, got.dir_y, got.outside);
        end
        if (want.outside) outside_seen++;
      end
      words_checked++;
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding",
               cycle_count, expected_headings.size());
      $display("stick_radial_deadzone_normalizer regression: fail");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    zone_radius = RADIUS_BITS'(RADIUS_RESET);
    idle_enable = 1'b1;
    stall_left = 0;
    cycle_count = 0;
    mismatch_count = 0;
    words_checked = 0;
    outside_seen = 0;
    radius_settings = 1;

    // Hold reset low, then release it at a falling edge.
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_radius();
    test_zero_radius();
    test_full_radius();
    test_random_radii();
    test_back_to_back();

    // Wait out the pipeline so a stray extra word would still be caught.
    drain_stream();
    repeat (LATENCY + 10) @(negedge clk);

    if (expected_headings.size() != 0) begin
      mismatch_count++;
      $display("%0d expected words never arrived", expected_headings.size());
    end

    $display("checked %0d words over %0d radius settings, zero and full radius included",
             words_checked, radius_settings);
    $display("%0d words outside the zone, %0d inside or on the circle",
             outside_seen, words_checked - outside_seen);
    if (mismatch_count == 0) begin
      $display("stick_radial_deadzone_normalizer regression: pass");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("stick_radial_deadzone_normalizer regression: fail");
    end
    $finish;
  end

endmodule
